/* src/ptba_pkg.sv */
// Package with the sizes, opcodes and entry layout of the token bucket admission unit.
`timescale 1ns / 1ps

package ptba_pkg;

	localparam int NUM_PORTS       = 64;
	localparam int QUEUES_PER_PORT = 8;
	localparam int ENTRY_COUNT     = NUM_PORTS * QUEUES_PER_PORT;
	localparam int ENTRY_AW        = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int PORT_AW         = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	localparam int PORT_W  = 6;
	localparam int QUEUE_W = 3;
	localparam int TIME_W  = 48;
	localparam int LEN_W   = 16;
	localparam int RATE_W  = 32;
	localparam int CAP_W   = 32;
	localparam int TOK_W   = 48;
	localparam int FRAC_W  = 16;

	localparam logic OP_ADMIT   = 1'b0;
	localparam logic OP_PROGRAM = 1'b1;

	typedef logic [QUEUES_PER_PORT-1:0] qmask_t;

	typedef struct packed {
		logic              configured;
		logic              eligible;
		logic [RATE_W-1:0] rate;
		logic [CAP_W-1:0]  capacity;
		logic [TOK_W-1:0]  tokens;
		logic [TIME_W-1:0] refill_stamp;
	} entry_t;

endpackage

/* src/per_queue_token_bucket_admission_unit.sv */
// Token bucket admission table with one bucket per port and queue, held in on-chip memory.
`timescale 1ns / 1ps

// Each item is handled in turn: it is accepted and its entry and port mask are read from
// two single-port synchronous memories, the elapsed time is multiplied by the rate, the
// refill is added and saturated at capacity, and then the length is charged and the entry
// written back while the result beat is loaded into the output register. The unit does not
// take a new item until it is through with the last one: an item is accepted only once the
// previous one has written its entry back through that read-multiply-add-write sequence,
// so no two accesses to the same entry ever overlap. The result register lets a new item
// be accepted while the previous result beat still waits on out_stall. After reset the
// unit runs a clearing pass over the entry memory, one entry per cycle, clearing the
// configured and eligible flags and the port masks; in_stall stays high until it is done.
// Tokens are unsigned 32.16 fixed point and the rate is unsigned 16.16 bytes per tick. A
// packet on an unconfigured entry, or on a port or queue outside the table, is always
// admitted.
module per_queue_token_bucket_admission_unit
	import ptba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [PORT_W-1:0]  port_index,
	input  logic [QUEUE_W-1:0] queue_index,
	input  logic [TIME_W-1:0]  now_ticks,
	input  logic [LEN_W-1:0]   packet_length,
	input  logic [RATE_W-1:0]  fill_rate,
	input  logic [CAP_W-1:0]   bucket_capacity,
	input  logic               queue_eligible,

	output logic               out_valid,
	input  logic               out_stall,
	output logic               admitted,
	output logic               port_active
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	localparam logic [ENTRY_AW-1:0] ENTRY_LAST = ENTRY_AW'(ENTRY_COUNT - 1);
	localparam int GAIN_W = TIME_W + RATE_W;

	// Storage: the entry table and the per-port eligible masks.
	entry_t entry_mem [ENTRY_COUNT];
	qmask_t mask_mem  [NUM_PORTS];

	logic [2:0]          state_q;
	logic [ENTRY_AW-1:0] clr_cnt_q;

	// The item being worked on.
	logic                op_q;
	logic                port_ok_q;
	logic                queue_ok_q;
	logic [ENTRY_AW-1:0] entry_addr_q;
	logic [PORT_AW-1:0]  port_addr_q;
	logic [QUEUE_W-1:0]  queue_q;
	logic [TIME_W-1:0]   now_q;
	logic [LEN_W-1:0]    len_q;
	logic [RATE_W-1:0]   rate_in_q;
	logic [CAP_W-1:0]    cap_in_q;
	logic                elig_in_q;

	// Registered memory read data.
	entry_t              ent_rd_q;
	qmask_t              mask_rd_q;

	// Refill arithmetic registers.
	logic [63:0]         prod_lo_q;
	logic [47:0]         prod_hi_q;
	logic                advance_q;
	logic [TOK_W-1:0]    tok_new_q;

	logic                out_valid_q;
	logic                admitted_q;
	logic                port_active_q;

	logic                accept;
	logic                out_free;
	logic                fin_go;
	logic [ENTRY_AW-1:0] entry_addr_d;
	logic [PORT_AW-1:0]  port_addr_d;
	logic                port_ok_d;
	logic                queue_ok_d;
	logic [TIME_W-1:0]   elapsed;
	logic [GAIN_W:0]     refill_sum;
	logic [TOK_W-1:0]    cap_fx;
	logic [TOK_W-1:0]    need;
	logic                enough;
	qmask_t              queue_bit;
	qmask_t              mask_new;
	entry_t              ent_wd;
	logic                ent_we;
	logic [ENTRY_AW-1:0] ent_wa;
	logic                mask_we;
	logic [PORT_AW-1:0]  mask_wa;
	qmask_t              mask_wd;
	logic                res_admitted;
	logic                res_active;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign fin_go   = (state_q == ST_FIN) && out_free;

	assign port_ok_d    = (32'(port_index) < NUM_PORTS);
	assign queue_ok_d   = (32'(queue_index) < QUEUES_PER_PORT);
	assign port_addr_d  = PORT_AW'(port_index);
	assign entry_addr_d = ENTRY_AW'(ENTRY_AW'(port_index) * ENTRY_AW'(QUEUES_PER_PORT)
		+ ENTRY_AW'(queue_index));

	// Elapsed time is split into a 32-bit and a 16-bit part so that each product stays
	// within a 32 by 32 multiplier.
	assign elapsed = now_q - ent_rd_q.refill_stamp;

	// The stored tokens never exceed capacity, so a single saturation of the exact sum
	// covers both the bucket filling up and a gain far beyond capacity.
	assign cap_fx     = {ent_rd_q.capacity, {FRAC_W{1'b0}}};
	assign refill_sum = (GAIN_W+1)'({prod_hi_q, 32'b0}) + (GAIN_W+1)'(prod_lo_q)
		+ (GAIN_W+1)'(ent_rd_q.tokens);

	assign need   = {len_q, {FRAC_W{1'b0}}};
	assign enough = (tok_new_q >= need);

	assign queue_bit = qmask_t'(1) << queue_q;
	assign mask_new  = elig_in_q ? (mask_rd_q | queue_bit) : (mask_rd_q & ~queue_bit);

	// Result and write-back of the final step, and the writes of the clearing pass.
	always_comb begin
		ent_wd       = ent_rd_q;
		ent_we       = 1'b0;
		ent_wa       = entry_addr_q;
		mask_we      = 1'b0;
		mask_wa      = port_addr_q;
		mask_wd      = mask_new;
		res_admitted = 1'b0;
		res_active   = 1'b0;
		if (state_q == ST_CLEAR) begin
			ent_we  = 1'b1;
			ent_wa  = clr_cnt_q;
			ent_wd  = '0;
			mask_we = (32'(clr_cnt_q) < NUM_PORTS);
			mask_wa = PORT_AW'(clr_cnt_q);
			mask_wd = '0;
		end else if (fin_go) begin
			if (port_ok_q) begin
				res_active = |mask_rd_q;
			end
			if (op_q == OP_PROGRAM) begin
				if (port_ok_q && queue_ok_q) begin
					ent_we                 = 1'b1;
					ent_wd.configured      = 1'b1;
					ent_wd.eligible        = elig_in_q;
					ent_wd.rate            = rate_in_q;
					ent_wd.capacity        = cap_in_q;
					ent_wd.tokens          = {cap_in_q, {FRAC_W{1'b0}}};
					ent_wd.refill_stamp    = now_q;
					mask_we                = 1'b1;
					res_active             = |mask_new;
				end
			end else begin
				res_admitted = 1'b1;
				if (port_ok_q && queue_ok_q && ent_rd_q.configured) begin
					ent_we       = 1'b1;
					res_admitted = enough;
					ent_wd.tokens = enough ? (tok_new_q - need) : tok_new_q;
					if (advance_q) begin
						ent_wd.refill_stamp = now_q;
					end
				end
			end
		end
	end

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[ent_wa] <= ent_wd;
		end
		if (accept) begin
			ent_rd_q <= entry_mem[entry_addr_d];
		end
	end

	// Port mask memory.
	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_mem[mask_wa] <= mask_wd;
		end
		if (accept) begin
			mask_rd_q <= mask_mem[port_addr_d];
		end
	end

	// Item fields and the arithmetic pipeline registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= opcode;
			port_ok_q    <= port_ok_d;
			queue_ok_q   <= queue_ok_d;
			entry_addr_q <= entry_addr_d;
			port_addr_q  <= port_addr_d;
			queue_q      <= queue_index;
			now_q        <= now_ticks;
			len_q        <= packet_length;
			rate_in_q    <= fill_rate;
			cap_in_q     <= bucket_capacity;
			elig_in_q    <= queue_eligible;
		end
		if (state_q == ST_READ) begin
			prod_lo_q <= 64'(elapsed[31:0]) * 64'(ent_rd_q.rate);
			prod_hi_q <= 48'(elapsed[TIME_W-1:32]) * 48'(ent_rd_q.rate);
			advance_q <= (now_q > ent_rd_q.refill_stamp);
		end
		if (state_q == ST_SUM) begin
			if (!advance_q) begin
				tok_new_q <= ent_rd_q.tokens;
			end else if (refill_sum > (GAIN_W+1)'(cap_fx)) begin
				tok_new_q <= cap_fx;
			end else begin
				tok_new_q <= refill_sum[TOK_W-1:0];
			end
		end
		if (fin_go) begin
			admitted_q    <= res_admitted;
			port_active_q <= res_active;
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ENTRY_AW'(1);
					if (clr_cnt_q == ENTRY_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign admitted    = admitted_q;
	assign port_active = port_active_q;

endmodule

/* bench/tb.sv */
// Self-checking testbench for the per-queue token bucket admission unit.
`timescale 1ns / 1ps

module tb
	import ptba_pkg::*;
();

	// One request beat as the sender presents it. Fields that the opcode does not
	// use are still driven with random values, so that every input bit toggles.
	typedef struct {
		bit               opcode;
		bit [PORT_W-1:0]  port;
		bit [QUEUE_W-1:0] queue;
		bit [TIME_W-1:0]  now;
		bit [LEN_W-1:0]   length;
		bit [RATE_W-1:0]  rate;
		bit [CAP_W-1:0]   capacity;
		bit               eligible;
	} bucket_req_t;

	// One result beat: the admission verdict and the port activity flag.
	typedef struct {
		bit admitted;
		bit port_active;
	} verdict_t;

	// The scoreboard keeps its own copy of the bucket table and works out the
	// verdict of every request beat that the unit accepts. Result beats are then
	// matched in order against the oldest verdict still pending.
	class admission_scoreboard;
		bit               configured [ENTRY_COUNT];
		bit [RATE_W-1:0]  rate       [ENTRY_COUNT];
		bit [CAP_W-1:0]   capacity   [ENTRY_COUNT];
		bit [TOK_W-1:0]   tokens     [ENTRY_COUNT];
		bit [TIME_W-1:0]  stamp      [ENTRY_COUNT];
		qmask_t           port_mask  [NUM_PORTS];
		verdict_t         expected_verdicts [$];
		int               mismatches;

		function void note_request(bucket_req_t r);
			verdict_t  v;
			int        e;
			bit [63:0] cap_fx;
			bit [63:0] tok;
			bit [63:0] elapsed;
			bit [63:0] need;
			v.admitted    = 1'b0;
			v.port_active = 1'b0;
			if (r.port < NUM_PORTS) begin
				if (r.queue < QUEUES_PER_PORT) begin
					e = r.port * QUEUES_PER_PORT + r.queue;
					if (r.opcode == OP_PROGRAM) begin
						// Programming refills the bucket to the brim and restarts its clock.
						configured[e]            = 1'b1;
						rate[e]                  = r.rate;
						capacity[e]              = r.capacity;
						tokens[e]                = TOK_W'(r.capacity) << FRAC_W;
						stamp[e]                 = r.now;
						port_mask[r.port][r.queue] = r.eligible;
					end else if (!configured[e]) begin
						v.admitted = 1'b1;
					end else begin
						cap_fx = 64'(capacity[e]) << FRAC_W;
						tok    = 64'(tokens[e]);
						// Refill only when time moved forward; a wrapped timer keeps the stamp.
						if (r.now > stamp[e]) begin
							elapsed = 64'(r.now - stamp[e]);
							if (rate[e] != 0) begin
								// Compare against the headroom first so the product never
								// has to be formed beyond the capacity.
								if (elapsed > cap_fx / 64'(rate[e])) begin
									tok = cap_fx;
								end else begin
									tok = tok + elapsed * 64'(rate[e]);
									if (tok > cap_fx)
										tok = cap_fx;
								end
							end else if (tok > cap_fx) begin
								tok = cap_fx;
							end
							stamp[e] = r.now;
						end
						need = 64'(r.length) << FRAC_W;
						if (tok >= need) begin
							tokens[e]  = TOK_W'(tok - need);
							v.admitted = 1'b1;
						end else begin
							tokens[e]  = TOK_W'(tok);
						end
					end
				end else if (r.opcode == OP_ADMIT) begin
					v.admitted = 1'b1;
				end
				v.port_active = (port_mask[r.port] != '0);
			end else if (r.opcode == OP_ADMIT) begin
				v.admitted = 1'b1;
			end
			expected_verdicts.push_back(v);
		endfunction

		function void check_verdict(logic got_admitted, logic got_active);
			verdict_t v;
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing pending: expected none, actual %b/%b",
					$time, got_admitted, got_active);
				return;
			end
			v = expected_verdicts.pop_front();
			if (got_admitted !== v.admitted) begin
				mismatches++;
				$display("%0t: admitted mismatch: expected %b actual %b",
					$time, v.admitted, got_admitted);
			end
			if (got_active !== v.port_active) begin
				mismatches++;
				$display("%0t: port_active mismatch: expected %b actual %b",
					$time, v.port_active, got_active);
			end
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               opcode;
	logic [PORT_W-1:0]  port_index;
	logic [QUEUE_W-1:0] queue_index;
	logic [TIME_W-1:0]  now_ticks;
	logic [LEN_W-1:0]   packet_length;
	logic [RATE_W-1:0]  fill_rate;
	logic [CAP_W-1:0]   bucket_capacity;
	logic               queue_eligible;
	logic               out_valid;
	logic               out_stall;
	logic               admitted;
	logic               port_active;

	admission_scoreboard board = new();

	// Idling on both sides switches between normal mode and quiet stretches in
	// which beats follow each other with no gaps at all.
	bit                 send_quiet;
	bit                 recv_quiet;
	bit [TIME_W-1:0]    clock_now;
	bit [PORT_W-1:0]    hot_ports [4];

	per_queue_token_bucket_admission_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.port_index     (port_index),
		.queue_index    (queue_index),
		.now_ticks      (now_ticks),
		.packet_length  (packet_length),
		.fill_rate      (fill_rate),
		.bucket_capacity(bucket_capacity),
		.queue_eligible (queue_eligible),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.admitted       (admitted),
		.port_active    (port_active)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap(bit quiet);
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic bit [TIME_W-1:0] random_time();
		bit [TIME_W-1:0] t;
		t[31:0]      = $urandom();
		t[TIME_W-1:32] = (TIME_W-32)'($urandom());
		return t;
	endfunction

	// Admit beat; the program-only fields carry noise.
	function automatic bucket_req_t admit_of(int port, int queue, bit [TIME_W-1:0] now,
			int length);
		bucket_req_t r;
		r.opcode   = OP_ADMIT;
		r.port     = PORT_W'(port);
		r.queue    = QUEUE_W'(queue);
		r.now      = now;
		r.length   = LEN_W'(length);
		r.rate     = $urandom();
		r.capacity = $urandom();
		r.eligible = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// Program beat; the length field carries noise.
	function automatic bucket_req_t program_of(int port, int queue, bit [TIME_W-1:0] now,
			bit [RATE_W-1:0] rate, bit [CAP_W-1:0] capacity, bit eligible);
		bucket_req_t r;
		r.opcode   = OP_PROGRAM;
		r.port     = PORT_W'(port);
		r.queue    = QUEUE_W'(queue);
		r.now      = now;
		r.length   = LEN_W'($urandom());
		r.rate     = rate;
		r.capacity = capacity;
		r.eligible = eligible;
		return r;
	endfunction

	// Random traffic concentrates on a few ports so that programmed buckets are
	// hit again and again, with time mostly creeping forward in small steps. A
	// small share of beats uses full-range values and arbitrary time jumps.
	function automatic bucket_req_t random_req();
		bucket_req_t r;
		int          port;
		int          roll;
		bit          wide;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			clock_now = random_time();
		else
			clock_now = clock_now + TIME_W'($urandom_range(0, 30));
		port = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_PORTS - 1)
			: hot_ports[$urandom_range(0, 3)];
		wide = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 99) < 15) begin
			r = program_of(port, $urandom_range(0, QUEUES_PER_PORT - 1), clock_now,
				wide ? $urandom() : $urandom_range(0, 32'h0004_0000),
				wide ? $urandom() : $urandom_range(0, 4000),
				1'($urandom_range(0, 1)));
		end else begin
			r = admit_of(port, $urandom_range(0, QUEUES_PER_PORT - 1), clock_now,
				wide ? $urandom_range(0, 65535) : $urandom_range(0, 1500));
		end
		return r;
	endfunction

	// Present one request beat and hold it until the unit takes it. The valid is
	// only lowered when a gap is inserted, so it is never dropped and raised in
	// the same time step.
	task automatic drive_request(bucket_req_t r);
		int gap;
		gap = pick_gap(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		opcode          <= r.opcode;
		port_index      <= r.port;
		queue_index     <= r.queue;
		now_ticks       <= r.now;
		packet_length   <= r.length;
		fill_rate       <= r.rate;
		bucket_capacity <= r.capacity;
		queue_eligible  <= r.eligible;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(r);
		if ($urandom_range(0, 59) == 0)
			send_quiet = !send_quiet;
	endtask

	// Result side: a beat is taken at every edge where out_valid is high and our
	// stall was low, and the stall for the next cycle is chosen afterwards.
	initial begin
		int stall_left;
		out_stall <= 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				board.check_verdict(admitted, port_active);
			if ($urandom_range(0, 199) == 0)
				recv_quiet = !recv_quiet;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall  <= 1'b0;
				stall_left = pick_gap(recv_quiet);
			end
		end
	end

	initial begin
		bucket_req_t plan [$];
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		opcode          <= OP_ADMIT;
		port_index      <= '0;
		queue_index     <= '0;
		now_ticks       <= '0;
		packet_length   <= '0;
		fill_rate       <= '0;
		bucket_capacity <= '0;
		queue_eligible  <= 1'b0;
		hot_ports[0] = '0;
		hot_ports[1] = PORT_W'(NUM_PORTS - 1);
		hot_ports[2] = PORT_W'($urandom_range(1, NUM_PORTS - 2));
		hot_ports[3] = PORT_W'($urandom_range(1, NUM_PORTS - 2));

		// Directed beats. An unconfigured entry admits anything.
		plan.push_back(admit_of(0, 0, 0, 65535));
		// Empty bucket with no refill: only a zero-length packet gets through.
		plan.push_back(program_of(0, 0, 100, 0, 0, 1'b1));
		plan.push_back(admit_of(0, 0, 200, 0));
		plan.push_back(admit_of(0, 0, 300, 1));
		// Largest rate and capacity near the top of the timer, then a refill whose
		// gain overshoots the capacity, then a wrapped timer that must not refill.
		plan.push_back(program_of(NUM_PORTS - 1, QUEUES_PER_PORT - 1, 48'hFFFF_FFFF_FF00,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		plan.push_back(admit_of(NUM_PORTS - 1, QUEUES_PER_PORT - 1, 48'hFFFF_FFFF_FF00, 65535));
		plan.push_back(admit_of(NUM_PORTS - 1, QUEUES_PER_PORT - 1, 48'hFFFF_FFFF_FFFF, 65535));
		plan.push_back(admit_of(NUM_PORTS - 1, QUEUES_PER_PORT - 1, 5, 65535));
		// One byte per tick into a 100-byte bucket: drain it, starve it, hit the
		// exact boundary, then saturate after a long idle.
		plan.push_back(program_of(5, 3, 1000, 32'h0001_0000, 100, 1'b0));
		plan.push_back(admit_of(5, 3, 1000, 100));
		plan.push_back(admit_of(5, 3, 1000, 1));
		plan.push_back(admit_of(5, 3, 1040, 50));
		plan.push_back(admit_of(5, 3, 1040, 40));
		plan.push_back(admit_of(5, 3, 100000, 100));
		plan.push_back(admit_of(5, 3, 100000, 1));
		// Setting and clearing an eligible queue flips the port activity flag.
		plan.push_back(program_of(5, 5, 0, 32'h0000_8000, 10, 1'b1));
		plan.push_back(program_of(5, 5, 0, 32'h0000_8000, 10, 1'b0));
		plan.push_back(admit_of(5, 3, 1, 0));
		// Smallest nonzero rate: a whole byte takes 65536 ticks to build up.
		plan.push_back(program_of(5, 3, 2000, 32'h0000_0001, 1, 1'b0));
		plan.push_back(admit_of(5, 3, 2000, 1));
		plan.push_back(admit_of(5, 3, 2000 + 65535, 1));
		plan.push_back(admit_of(5, 3, 2000 + 65536, 1));
		plan.push_back(admit_of(40, 2, random_time(), $urandom_range(0, 65535)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			drive_request(plan[i]);
		clock_now = 0;
		repeat (500)
			drive_request(random_req());
		in_valid <= 1'b0;

		// Drain the pipeline, then keep the clock running so that any stray result beat
		// still shows.
		while (board.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (board.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: covers the clearing pass after reset and every beat at its
	// longest gaps on both sides many times over.
	initial begin
		#6_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
src/ptba_pkg.sv
src/per_queue_token_bucket_admission_unit.sv
bench/tb.sv
